[hdl/plin_pkg.sv]
// Shared types and constants for the piecewise linear interpolation block.
// No dependencies; imported by every module of the block except plin_ram.
package plin_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int DATA_W     = 32;
    localparam int MIN_POINTS = 2;
    localparam int QUO_W      = 2 * DATA_W;
    localparam int BITCNT_W   = $clog2(QUO_W);
    localparam int BIG_BIT    = 40;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RD_NEXT,
        RD_LAST,
        RD_ZERO
    } rd_sel_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic    ld_query;
        logic    wr_pt;
        rd_sel_t rd_sel;
        logic    set_force;
        logic    take_first;
        logic    walk_step;
        logic    take_cur;
        logic    setup;
        logic    mul;
        logic    div_step;
        logic    round;
        logic    finish;
        logic    load_out;
    } plin_cmd_t;

    typedef struct packed {
        logic below_first;
        logic walk_stop;
        logic zero_span;
        logic div_last;
    } plin_sts_t;

endpackage

[hdl/plin_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plin_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/plin_dp.sv]
// Datapath: breakpoint RAM, segment walk registers, multiplier, serial divider,
// rounding, saturation and output register. Depends on plin_pkg and plin_ram.
module plin_dp
    import plin_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  plin_cmd_t                cmd,
    output plin_sts_t                sts,
    input  logic                     cfg_valid,
    input  logic [CNT_W-1:0]         cfg_data,
    input  logic [IDX_W-1:0]         point_index,
    input  logic signed [DATA_W-1:0] point_x,
    input  logic signed [DATA_W-1:0] point_y,
    input  logic signed [DATA_W-1:0] query_x,
    output logic signed [DATA_W-1:0] result_y,
    output logic                     zero_span,
    output logic                     saturated
);

    logic [CNT_W-1:0]         cnt_reg;
    logic signed [DATA_W-1:0] q_reg;
    logic [IDX_W-1:0]         last_idx_reg, last_idx_next;
    logic [IDX_W-1:0]         k_reg;
    logic                     force_reg;
    point_t                   prev_reg, cur_reg;
    logic [DATA_W-1:0]        a_reg, b_reg, span_mag_reg;
    logic                     neg_reg, zs_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [BITCNT_W-1:0]      bit_cnt_reg;
    logic                     big_reg;
    logic [BIG_BIT:0]         mag_reg;
    logic signed [DATA_W-1:0] res_y_reg, out_y_reg;
    logic                     res_sat_reg, out_zs_reg, out_sat_reg;

    logic [IDX_W-1:0]         raddr;
    logic [2*DATA_W-1:0]      rdata_raw;
    point_t                   rd;

    logic signed [DATA_W:0]   dx_s, dy_s, sp_s;
    logic [DATA_W:0]          dx_abs, dy_abs, sp_abs;
    logic [DATA_W:0]          div_tmp, div_sub;
    logic                     div_ge, rnd;
    logic signed [BIG_BIT+1:0] y0_ext, mag_ext, sum;
    logic                     sum_hi, sum_lo;

    plin_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_pt),
        .waddr (point_index),
        .wdata ({point_y, point_x}),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rd = point_t'(rdata_raw);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_LAST: raddr = last_idx_reg;
            RD_ZERO: raddr = '0;
            default: raddr = k_reg + IDX_W'(1);
        endcase
    end

    // clamp point_count to [MIN_POINTS, MAX_POINTS], keep index of last point
    always_comb
    begin
        if (cnt_reg < CNT_W'(MIN_POINTS))
        begin
            last_idx_next = IDX_W'(MIN_POINTS - 1);
        end
        else if (cnt_reg > CNT_W'(MAX_POINTS))
        begin
            last_idx_next = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        dx_s   = {q_reg[DATA_W-1], q_reg} - {prev_reg.x[DATA_W-1], prev_reg.x};
        dy_s   = {cur_reg.y[DATA_W-1], cur_reg.y} - {prev_reg.y[DATA_W-1], prev_reg.y};
        sp_s   = {cur_reg.x[DATA_W-1], cur_reg.x} - {prev_reg.x[DATA_W-1], prev_reg.x};
        dx_abs = dx_s[DATA_W] ? (DATA_W+1)'(-dx_s) : dx_s;
        dy_abs = dy_s[DATA_W] ? (DATA_W+1)'(-dy_s) : dy_s;
        sp_abs = sp_s[DATA_W] ? (DATA_W+1)'(-sp_s) : sp_s;
    end

    always_comb
    begin
        div_tmp = {rem_reg, quo_reg[QUO_W-1]};
        div_ge  = div_tmp >= {1'b0, span_mag_reg};
        div_sub = div_tmp - {1'b0, span_mag_reg};
        rnd     = {rem_reg, 1'b0} >= {1'b0, span_mag_reg};
    end

    always_comb
    begin
        y0_ext  = {{(BIG_BIT+2-DATA_W){prev_reg.y[DATA_W-1]}}, prev_reg.y};
        mag_ext = {1'b0, mag_reg};
        sum     = neg_reg ? y0_ext - mag_ext : y0_ext + mag_ext;
        sum_hi  = !sum[BIG_BIT+1] && (|sum[BIG_BIT:DATA_W-1]);
        sum_lo  = sum[BIG_BIT+1] && !(&sum[BIG_BIT:DATA_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_W'(MIN_POINTS);
        end
        else if (cfg_valid)
        begin
            cnt_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            q_reg        <= query_x;
            last_idx_reg <= last_idx_next;
            k_reg        <= '0;
        end
        if (cmd.set_force)
        begin
            force_reg <= q_reg > rd.x;
        end
        if (cmd.take_first)
        begin
            res_y_reg   <= rd.y;
            res_sat_reg <= 1'b0;
            zs_reg      <= 1'b0;
        end
        if (cmd.walk_step)
        begin
            prev_reg <= rd;
            k_reg    <= k_reg + IDX_W'(1);
        end
        if (cmd.take_cur)
        begin
            cur_reg <= rd;
        end
        if (cmd.setup)
        begin
            a_reg        <= dx_abs[DATA_W-1:0];
            b_reg        <= dy_abs[DATA_W-1:0];
            span_mag_reg <= sp_abs[DATA_W-1:0];
            neg_reg      <= dx_s[DATA_W] ^ dy_s[DATA_W] ^ sp_s[DATA_W];
            zs_reg       <= sp_s == '0;
            res_y_reg    <= '0;
            res_sat_reg  <= 1'b0;
        end
        if (cmd.mul)
        begin
            quo_reg     <= a_reg * b_reg;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[QUO_W-2:0], div_ge};
            rem_reg     <= div_ge ? div_sub[DATA_W-1:0] : div_tmp[DATA_W-1:0];
            bit_cnt_reg <= bit_cnt_reg + BITCNT_W'(1);
        end
        if (cmd.round)
        begin
            big_reg <= |quo_reg[QUO_W-1:BIG_BIT];
            mag_reg <= {1'b0, quo_reg[BIG_BIT-1:0]} + (BIG_BIT+1)'(rnd);
        end
        if (cmd.finish)
        begin
            if (big_reg || sum_hi || sum_lo)
            begin
                res_sat_reg <= 1'b1;
                if ((big_reg && neg_reg) || (!big_reg && sum_lo))
                begin
                    res_y_reg <= {1'b1, {(DATA_W-1){1'b0}}};
                end
                else
                begin
                    res_y_reg <= {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
            else
            begin
                res_sat_reg <= 1'b0;
                res_y_reg   <= sum[DATA_W-1:0];
            end
        end
        if (cmd.load_out)
        begin
            out_y_reg   <= res_y_reg;
            out_zs_reg  <= zs_reg;
            out_sat_reg <= res_sat_reg;
        end
    end

    assign sts.below_first = q_reg < rd.x;
    assign sts.walk_stop   = (k_reg == last_idx_reg) || (!force_reg && (q_reg <= rd.x));
    assign sts.zero_span   = zs_reg;
    assign sts.div_last    = bit_cnt_reg == {BITCNT_W{1'b1}};

    assign result_y  = out_y_reg;
    assign zero_span = out_zs_reg;
    assign saturated = out_sat_reg;

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (k_reg < last_idx_reg))
        else $error("segment walk past last point");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < span_mag_reg))
        else $error("divider remainder not below divisor");

endmodule

[hdl/plin_ctrl.sv]
// Controller state machine: handshakes and sequencing of load, walk, divide.
// Depends on plin_pkg.
module plin_ctrl
    import plin_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      action,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  plin_sts_t sts,
    output plin_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD_LAST   = 4'd1;
    localparam logic [3:0] S_RD_FIRST  = 4'd2;
    localparam logic [3:0] S_CHK_FIRST = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_SETUP     = 4'd5;
    localparam logic [3:0] S_MUL       = 4'd6;
    localparam logic [3:0] S_DIV       = 4'd7;
    localparam logic [3:0] S_ROUND     = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_NEXT;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (action == ACT_QUERY)
                    begin
                        cmd.ld_query = 1'b1;
                        state_next   = S_RD_LAST;
                    end
                    else
                    begin
                        cmd.wr_pt = 1'b1;
                    end
                end
            end
            S_RD_LAST:
            begin
                cmd.rd_sel = RD_LAST;
                state_next = S_RD_FIRST;
            end
            S_RD_FIRST:
            begin
                cmd.rd_sel    = RD_ZERO;
                cmd.set_force = 1'b1;
                state_next    = S_CHK_FIRST;
            end
            S_CHK_FIRST:
            begin
                if (sts.below_first)
                begin
                    cmd.take_first = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.walk_stop)
                begin
                    cmd.take_cur = 1'b1;
                    state_next   = S_SETUP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sts.zero_span)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && action == ACT_QUERY) |=> !s_tready)
        else $error("request taken while query in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten before taken");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !sts.zero_span)
        else $error("divide started on zero span");

endmodule

[hdl/piecewise_linear_interp.sv]
// Piecewise linear interpolation over a table of up to 64 Q16.16 breakpoints.
// A load request writes one breakpoint. A query walks the table to the
// segment for query_x: the walk reads one breakpoint per cycle from the
// single read port of the table RAM, and the 64-bit by 32-bit restoring
// divider retires one quotient bit per cycle. Below-first-point queries skip
// the walk and the divider, zero-span queries skip the divider. A finished
// result waits in the output register while the next request is taken.
// Table contents are undefined until written; there is no clearing pass
// after reset.
// Depends on plin_pkg, plin_ctrl, plin_dp.
module piecewise_linear_interp
    import plin_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [103:0]     s_tdata,   // point_index, point_x, point_y, query_x, zero pad
    input  logic             s_tuser,   // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // result_y
    output logic [1:0]       m_tuser,   // zero_span, saturated
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    plin_cmd_t                cmd;
    plin_sts_t                sts;
    logic signed [DATA_W-1:0] result_y;
    logic                     zero_span;
    logic                     saturated;

    assign cfg_ready = 1'b1;

    plin_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plin_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .point_index (s_tdata[5:0]),
        .point_x     (s_tdata[37:6]),
        .point_y     (s_tdata[69:38]),
        .query_x     (s_tdata[101:70]),
        .result_y    (result_y),
        .zero_span   (zero_span),
        .saturated   (saturated)
    );

    assign m_tdata = result_y;
    assign m_tuser = {saturated, zero_span};

endmodule

[tb/tb_piecewise_linear_interp.sv]
// Self-checking testbench for piecewise_linear_interp: breakpoint loads and queries
// on the request stream, checked against an in-bench predictor of the table search.
// Depends on plin_pkg and the piecewise_linear_interp RTL.
import plin_pkg::*;

class interp_scoreboard;
    typedef struct {
        logic [31:0] y;
        logic        zs;
        logic        sat;
    } interp_result_t;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    longint           x_tab[MAX_POINTS];
    longint           y_tab[MAX_POINTS];
    logic [CNT_W-1:0] point_count;
    interp_result_t   expected_results[$];
    int               errors;
    int               checked;
    int               zero_spans;
    int               saturations;
    int               requests;
    int               queries;

    function new();
        foreach (x_tab[i])
        begin
            x_tab[i] = 0;
            y_tab[i] = 0;
        end
        point_count = CNT_W'(MIN_POINTS);
        errors      = 0;
        checked     = 0;
        zero_spans  = 0;
        saturations = 0;
        requests    = 0;
        queries     = 0;
    endfunction

    function void set_point_count(logic [CNT_W-1:0] value);
        point_count = value;
    endfunction

    function int used_points();
        if (point_count < MIN_POINTS)
            return MIN_POINTS;
        if (point_count > MAX_POINTS)
            return MAX_POINTS;
        return int'(point_count);
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // y0 + dx*dy/span with exact product, round half away from zero, saturate
    function void eval_segment(input longint y0, input longint dx, input longint dy,
                               input longint span, output longint val, output bit sat);
        bit           neg;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] d;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        longint       mag;
        neg  = ((dx < 0) != (dy < 0)) != (span < 0);
        a    = {64'd0, (dx < 0) ? -dx : dx};
        b    = {64'd0, (dy < 0) ? -dy : dy};
        d    = {64'd0, (span < 0) ? -span : span};
        prod = a * b;
        quo  = prod / d;
        rem  = prod % d;
        sat  = 1'b0;
        if (quo >= (128'd1 << BIG_BIT))
        begin
            sat = 1'b1;
            val = neg ? Q_MIN : Q_MAX;
            return;
        end
        if (2 * rem >= d)
            quo = quo + 1;
        mag = longint'(quo[63:0]);
        val = neg ? y0 - mag : y0 + mag;
        if (val > Q_MAX)
        begin
            sat = 1'b1;
            val = Q_MAX;
        end
        else if (val < Q_MIN)
        begin
            sat = 1'b1;
            val = Q_MIN;
        end
    endfunction

    function interp_result_t predict_query(logic [31:0] qx);
        interp_result_t r;
        int             n;
        int             k;
        longint         q;
        longint         val;
        bit             sat;
        n     = used_points();
        q     = $signed(qx);
        r.zs  = 1'b0;
        r.sat = 1'b0;
        if (q < x_tab[0])
            r.y = y_tab[0][31:0];
        else
        begin
            if (q > x_tab[n-1])
                k = n - 1;
            else
            begin
                k = 1;
                while (k < n - 1 && q > x_tab[k])
                    k++;
            end
            if (x_tab[k] == x_tab[k-1])
            begin
                r.zs = 1'b1;
                r.y  = '0;
            end
            else
            begin
                eval_segment(y_tab[k-1], q - x_tab[k-1], y_tab[k] - y_tab[k-1],
                             x_tab[k] - x_tab[k-1], val, sat);
                r.y   = val[31:0];
                r.sat = sat;
            end
        end
        return r;
    endfunction

    function void note_request(logic act, logic [IDX_W-1:0] idx, logic [31:0] px,
                               logic [31:0] py, logic [31:0] qx);
        requests++;
        if (act == ACT_LOAD)
        begin
            x_tab[idx] = $signed(px);
            y_tab[idx] = $signed(py);
        end
        else
        begin
            queries++;
            expected_results.push_back(predict_query(qx));
        end
    endfunction

    task report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
                 $realtime, what, got, want, checked);
    endtask

    task check_result(logic [31:0] y, logic zs, logic sat);
        interp_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("unexpected result_y", $signed(y), 0);
            return;
        end
        want = expected_results.pop_front();
        checked++;
        if (y !== want.y)
            report_mismatch("result_y", $signed(y), $signed(want.y));
        if (zs !== want.zs)
            report_mismatch("zero_span", zs, want.zs);
        if (sat !== want.sat)
            report_mismatch("saturated", sat, want.sat);
        if (want.zs)
            zero_spans++;
        if (want.sat)
            saturations++;
    endtask
endclass

module tb_piecewise_linear_interp
    import plin_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_LIMIT    = 5000;
    localparam int     SETTLE_CYCLES = 200;
    localparam int     PHASE_ITEMS   = 70;
    localparam longint Q_MAX         = 64'sd2147483647;
    localparam longint Q_MIN         = -64'sd2147483648;
    localparam longint ONE           = 64'sd65536;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_FINE,
        SHAPE_DUPS,
        SHAPE_SCRAMBLED,
        SHAPE_STEEP
    } table_shape_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [103:0]     s_tdata;   // point_index, point_x, point_y, query_x, zero pad
    logic             s_tuser;   // action
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;   // result_y
    logic [1:0]       m_tuser;   // zero_span, saturated
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    interp_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               idle_cycles;
    int               count_plan[16] = '{2, 64, 0, 1, 127, 65, 3, 8, 16, 33, 63, 100, 5, 4,
                                         12, 40};

    piecewise_linear_interp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0], m_tuser[1]);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no progress for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v > Q_MAX)
            return 32'h7FFF_FFFF;
        if (v < Q_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    task automatic send_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] qx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tuser  <= act;
        s_tdata  <= {2'b00, qx, py, px, idx};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, idx, px, py, qx);
    endtask

    task automatic send_query(input logic [31:0] qx);
        send_item(ACT_QUERY, IDX_W'($urandom), $urandom, $urandom, qx);
    endtask

    task automatic send_load(input int slot, input longint px, input longint py);
        send_item(ACT_LOAD, IDX_W'(slot), clamp32(px), clamp32(py), $urandom);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_point_count(input int value);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data  <= CNT_W'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_point_count(CNT_W'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_table(input int n);
        table_shape_t shape;
        int           roll;
        longint       xv;
        longint       step_max;
        logic [31:0]  xw;
        logic [31:0]  yw;
        roll     = $urandom_range(0, 99);
        shape    = roll < 30 ? SHAPE_WIDE : roll < 55 ? SHAPE_FINE : roll < 70 ? SHAPE_DUPS
                 : roll < 80 ? SHAPE_SCRAMBLED : SHAPE_STEEP;
        step_max = 64'sd4294967295 / n;
        if (shape == SHAPE_WIDE)
            xv = Q_MIN + longint'($urandom_range(0, 32'(step_max)));
        else
            xv = longint'($urandom_range(0, 1 << 21)) - 64'sd1048576;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                case (shape)
                    SHAPE_WIDE:  xv += longint'($urandom_range(1, 32'(step_max)));
                    SHAPE_FINE:  xv += longint'($urandom_range(1, 1 << 16));
                    SHAPE_DUPS:  xv += ($urandom_range(0, 99) < 35) ? 0
                                     : longint'($urandom_range(1, 4096));
                    SHAPE_STEEP: xv += longint'($urandom_range(1, 8));
                    default: ;
                endcase
            end
            xw = (shape == SHAPE_SCRAMBLED) ? $urandom : clamp32(xv);
            case (shape)
                SHAPE_FINE:  yw = clamp32(longint'($urandom_range(0, 1 << 22)) - 64'sd2097152);
                SHAPE_STEEP: yw = i[0] ? (32'h8000_0000 | $urandom_range(0, 255))
                                       : (32'h7FFF_FFFF - $urandom_range(0, 255));
                default:     yw = $urandom;
            endcase
            send_item(ACT_LOAD, IDX_W'(i), xw, yw, $urandom);
        end
    endtask

    function automatic logic [31:0] pick_query();
        int     n;
        int     k;
        int     roll;
        longint lo;
        longint hi;
        longint qv;
        n    = sb.used_points();
        k    = $urandom_range(1, n - 1);
        roll = $urandom_range(0, 99);
        lo   = sb.x_tab[k-1];
        hi   = sb.x_tab[k];
        if (lo > hi)
        begin
            qv = lo;
            lo = hi;
            hi = qv;
        end
        if (roll < 30)
            qv = lo + longint'($urandom_range(0, 32'(hi - lo)));
        else if (roll < 45)
            qv = sb.x_tab[k];
        else if (roll < 60)
            qv = sb.x_tab[k] + longint'($urandom_range(0, 16)) - 64'sd8;
        else if (roll < 70)
            qv = sb.x_tab[0] - longint'($urandom_range(1, 1 << 16));
        else if (roll < 80)
            qv = sb.x_tab[n-1] + longint'($urandom_range(1, 1 << 20));
        else if (roll < 95)
            qv = longint'($signed($urandom));
        else
        begin
            case ($urandom_range(0, 3))
                0:       qv = Q_MIN;
                1:       qv = Q_MAX;
                2:       qv = 0;
                default: qv = -1;
            endcase
        end
        return clamp32(qv);
    endfunction

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_LOAD;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // full-range segment, ignored fields set
        send_item(ACT_LOAD, IDX_W'(0), 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_load(1, Q_MAX, Q_MIN);
        send_item(ACT_QUERY, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_query(32'h7FFF_FFFF);
        send_query(32'h0000_0000);
        send_query(32'hFFFF_FFFF);
        // rounding ties both ways, below first point, extrapolation
        send_load(0, 0, 0);
        send_load(1, 2, 1);
        send_query(32'd1);
        send_load(1, 2, -1);
        send_query(32'd1);
        send_query(clamp32(-5));
        send_query(32'd6);
        // equal x values
        send_load(1, 0, 7);
        send_query(32'd0);
        send_query(32'd10);
        // quotient overflow, positive and negative, and plain sum overflow
        send_load(1, 1, Q_MAX);
        send_query(32'h7FFF_FFFF);
        send_load(1, 1, Q_MIN);
        send_query(32'h7FFF_FFFF);
        send_load(0, 0, 64'sh7FFF_0000);
        send_load(1, ONE, Q_MAX);
        send_query(clamp32(2 * ONE));
        send_load(1, ONE, Q_MIN);
        send_query(clamp32(3 * ONE));

        foreach (count_plan[p])
        begin
            write_point_count(count_plan[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            load_table(sb.used_points());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    wait_results_done();
                if ($urandom_range(0, 99) < 12)
                    send_item(ACT_LOAD, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
                              $urandom, $urandom, $urandom);
                else
                    send_query(pick_query());
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d requests (%0d queries) over %0d point_count settings.",
                 sb.requests, sb.queries, $size(count_plan));
        $display("Checked %0d results: %0d zero-span, %0d saturated, %0d mismatches.",
                 sb.checked, sb.zero_spans, sb.saturations, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[filelist.f]
hdl/plin_pkg.sv
hdl/plin_ram.sv
hdl/plin_dp.sv
hdl/plin_ctrl.sv
hdl/piecewise_linear_interp.sv
tb/tb_piecewise_linear_interp.sv
